// ----- rtl/tge_pkg.sv -----
package tge_pkg;

  // widths fixed by the interface
  localparam int CFG_W        = 7;
  localparam int POS_W        = 6;
  localparam int ID_W         = 15;
  localparam int GRID_MAX_DEF = 64;

  // register and counter constants
  localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd10;
  localparam logic [CFG_W-1:0] GRID_MIN      = 7'd2;
  localparam logic [ID_W-1:0]  FIRST_ID      = 15'd4;

  // edge action codes
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_NEW    = 2'd1,
    ACT_EXTEND = 2'd2
  } action_t;

  // request held in the scan stage
  typedef struct packed {
    logic             solid;
    logic             east;
    logic             south;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last_col;
    logic             last_row;
  } scan_item_t;

  // one column entry of the row above
  typedef struct packed {
    logic            present;
    logic            west_flag;
    logic [ID_W-1:0] west_id;
    logic            east_flag;
    logic [ID_W-1:0] east_id;
  } above_t;

endpackage

// ----- rtl/tge_scan.sv -----
module tge_scan #(
  parameter int GRID_MAX = tge_pkg::GRID_MAX_DEF,
  parameter int AW       = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [tge_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cell_present,
  input  logic                     in_east_present,
  input  logic                     in_south_present,
  input  logic                     adv,
  output logic                     accept,
  output logic [AW-1:0]            rd_addr,
  output tge_pkg::scan_item_t      item,
  output logic                     item_vld
);
  import tge_pkg::*;

  logic [CFG_W-1:0] grid_size_r;
  logic [CFG_W-1:0] eff_size;
  logic [CFG_W-1:0] last_pos;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic             last_col;
  logic             last_row;
  logic             item_vld_r;
  scan_item_t       item_r;

  // grid size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
    end else if (cfg_wr_en) begin
      grid_size_r <= cfg_wr_data;
    end
  end

  // clamp grid size into the supported range
  always_comb begin
    if (grid_size_r < GRID_MIN) begin
      eff_size = GRID_MIN;
    end else if (grid_size_r > CFG_W'(GRID_MAX)) begin
      eff_size = CFG_W'(GRID_MAX);
    end else begin
      eff_size = grid_size_r;
    end
    last_pos = eff_size - CFG_W'(1);
  end

  // handshake: hold while the stage is full and cannot drain
  assign in_stall = item_vld_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = col_r[AW-1:0];

  // raster position of the incoming cell
  always_comb begin
    last_col = {1'b0, col_r} >= last_pos;
    last_row = {1'b0, row_r} >= last_pos;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + POS_W'(1);
    end else begin
      col_nxt = col_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      item_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        item_vld_r <= 1'b1;
      end else if (adv) begin
        item_vld_r <= 1'b0;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.solid    <= in_cell_present;
      item_r.east     <= in_east_present;
      item_r.south    <= in_south_present;
      item_r.col      <= col_r;
      item_r.row      <= row_r;
      item_r.last_col <= last_col;
      item_r.last_row <= last_row;
    end
  end

  assign item     = item_r;
  assign item_vld = item_vld_r;

endmodule

// ----- rtl/tge_row_mem.sv -----
module tge_row_mem #(
  parameter int DEPTH = tge_pkg::GRID_MAX_DEF,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tge_pkg::above_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tge_pkg::above_t wr_data
);
  import tge_pkg::*;

  above_t mem [DEPTH];
  above_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tge_edge.sv -----
module tge_edge #(
  parameter int AW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tge_pkg::scan_item_t        item,
  input  logic                       item_vld,
  input  tge_pkg::above_t            rd_data,
  output logic                       adv,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output tge_pkg::above_t            wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tge_pkg::POS_W-1:0]  out_cell_x,
  output logic [tge_pkg::POS_W-1:0]  out_cell_y,
  output logic [1:0]                 out_north_action,
  output logic [tge_pkg::ID_W-1:0]   out_north_id,
  output logic [1:0]                 out_west_action,
  output logic [tge_pkg::ID_W-1:0]   out_west_id,
  output logic [1:0]                 out_east_action,
  output logic [tge_pkg::ID_W-1:0]   out_east_id,
  output logic [1:0]                 out_south_action,
  output logic [tge_pkg::ID_W-1:0]   out_south_id,
  output logic                       out_last_cell
);
  import tge_pkg::*;

  // cell to the west and id counter
  logic            left_present_r;
  logic            left_north_flag_r;
  logic [ID_W-1:0] left_north_id_r;
  logic            left_south_flag_r;
  logic [ID_W-1:0] left_south_id_r;
  logic [ID_W-1:0] next_id_r, next_id_nxt;

  // result register
  logic             out_valid_r;
  logic [POS_W-1:0] cell_x_r, cell_y_r;
  action_t          north_act_r, west_act_r, east_act_r, south_act_r;
  logic [ID_W-1:0]  north_id_r, west_id_r, east_id_r, south_id_r;
  logic             last_cell_r;

  logic            has_left, has_above, last_cell;
  logic            need_n, need_w, need_e, need_s;
  logic            ext_n, ext_w, ext_e, ext_s;
  logic [ID_W-1:0] id_n, id_w, id_e, id_s, id_end;
  action_t         act_n, act_w, act_e, act_s;
  logic [ID_W-1:0] eid_n, eid_w, eid_e, eid_s;

  assign adv = item_vld && (!out_valid_r || !out_stall);

  // edge decisions for the held cell
  always_comb begin
    has_left  = (item.col != '0) && left_present_r;
    has_above = (item.row != '0) && rd_data.present;
    last_cell = item.last_col && item.last_row;

    need_n = item.solid && (item.row != '0) && !has_above;
    need_w = item.solid && (item.col != '0) && !has_left;
    need_e = item.solid && !item.last_col && !item.east;
    need_s = item.solid && !item.last_row && !item.south;

    ext_n = has_left && left_north_flag_r;
    ext_w = has_above && rd_data.west_flag;
    ext_e = has_above && rd_data.east_flag;
    ext_s = has_left && left_south_flag_r;

    // fresh ids are handed out in north, west, east, south order
    id_n   = next_id_r;
    id_w   = id_n + ID_W'(need_n && !ext_n);
    id_e   = id_w + ID_W'(need_w && !ext_w);
    id_s   = id_e + ID_W'(need_e && !ext_e);
    id_end = id_s + ID_W'(need_s && !ext_s);

    act_n = ACT_NONE;
    eid_n = '0;
    if (need_n) begin
      act_n = ext_n ? ACT_EXTEND : ACT_NEW;
      eid_n = ext_n ? left_north_id_r : id_n;
    end
    act_w = ACT_NONE;
    eid_w = '0;
    if (need_w) begin
      act_w = ext_w ? ACT_EXTEND : ACT_NEW;
      eid_w = ext_w ? rd_data.west_id : id_w;
    end
    act_e = ACT_NONE;
    eid_e = '0;
    if (need_e) begin
      act_e = ext_e ? ACT_EXTEND : ACT_NEW;
      eid_e = ext_e ? rd_data.east_id : id_e;
    end
    act_s = ACT_NONE;
    eid_s = '0;
    if (need_s) begin
      act_s = ext_s ? ACT_EXTEND : ACT_NEW;
      eid_s = ext_s ? left_south_id_r : id_s;
    end

    next_id_nxt = last_cell ? FIRST_ID : id_end;
  end

  // row-above entry for this column
  assign wr_en             = adv;
  assign wr_addr           = item.col[AW-1:0];
  assign wr_data.present   = item.solid;
  assign wr_data.west_flag = need_w;
  assign wr_data.west_id   = eid_w;
  assign wr_data.east_flag = need_e;
  assign wr_data.east_id   = eid_e;

  // west neighbor state and id counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_present_r    <= 1'b0;
      left_north_flag_r <= 1'b0;
      left_north_id_r   <= '0;
      left_south_flag_r <= 1'b0;
      left_south_id_r   <= '0;
      next_id_r         <= FIRST_ID;
    end else if (adv) begin
      left_present_r    <= item.solid;
      left_north_flag_r <= need_n;
      left_north_id_r   <= eid_n;
      left_south_flag_r <= need_s;
      left_south_id_r   <= eid_s;
      next_id_r         <= next_id_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      cell_x_r    <= item.col;
      cell_y_r    <= item.row;
      north_act_r <= act_n;
      north_id_r  <= eid_n;
      west_act_r  <= act_w;
      west_id_r   <= eid_w;
      east_act_r  <= act_e;
      east_id_r   <= eid_e;
      south_act_r <= act_s;
      south_id_r  <= eid_s;
      last_cell_r <= last_cell;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_x       = cell_x_r;
  assign out_cell_y       = cell_y_r;
  assign out_north_action = north_act_r;
  assign out_north_id     = north_id_r;
  assign out_west_action  = west_act_r;
  assign out_west_id      = west_id_r;
  assign out_east_action  = east_act_r;
  assign out_east_id      = east_id_r;
  assign out_south_action = south_act_r;
  assign out_south_id     = south_id_r;
  assign out_last_cell    = last_cell_r;

endmodule

// ----- rtl/tile_grid_edge_extractor.sv -----
// an accepted request is registered in the request stage, and its result in the result register of the edge stage
// throughput: one cell per cycle while out_stall is low, bounded by the single read port of the row-above memory
// the request stage reads the row-above entry, the edge stage decides and writes it back
// reset (rst_n low, synchronous): empties both stages, scan position to (0,0),
// next edge id to 4, grid size to 10; the row-above memory is not cleared
module tile_grid_edge_extractor #(
  parameter int GRID_MAX = tge_pkg::GRID_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tge_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cell_present,
  input  logic                       in_east_present,
  input  logic                       in_south_present,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tge_pkg::POS_W-1:0]  out_cell_x,
  output logic [tge_pkg::POS_W-1:0]  out_cell_y,
  output logic [1:0]                 out_north_action,
  output logic [tge_pkg::ID_W-1:0]   out_north_id,
  output logic [1:0]                 out_west_action,
  output logic [tge_pkg::ID_W-1:0]   out_west_id,
  output logic [1:0]                 out_east_action,
  output logic [tge_pkg::ID_W-1:0]   out_east_id,
  output logic [1:0]                 out_south_action,
  output logic [tge_pkg::ID_W-1:0]   out_south_id,
  output logic                       out_last_cell
);
  import tge_pkg::*;

  localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;

  logic       adv;
  logic       accept;
  logic [AW-1:0] rd_addr;
  scan_item_t item;
  logic       item_vld;
  above_t     rd_data;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  above_t     wr_data;

  // request stage and raster position
  tge_scan #(
    .GRID_MAX (GRID_MAX),
    .AW       (AW)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_present  (in_cell_present),
    .in_east_present  (in_east_present),
    .in_south_present (in_south_present),
    .adv              (adv),
    .accept           (accept),
    .rd_addr          (rd_addr),
    .item             (item),
    .item_vld         (item_vld)
  );

  // row-above storage
  tge_row_mem #(
    .DEPTH (GRID_MAX),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // edge decisions and result register
  tge_edge #(
    .AW (AW)
  ) u_edge (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (item),
    .item_vld         (item_vld),
    .rd_data          (rd_data),
    .adv              (adv),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_north_action (out_north_action),
    .out_north_id     (out_north_id),
    .out_west_action  (out_west_action),
    .out_west_id      (out_west_id),
    .out_east_action  (out_east_action),
    .out_east_id      (out_east_id),
    .out_south_action (out_south_action),
    .out_south_id     (out_south_id),
    .out_last_cell    (out_last_cell)
  );

endmodule

// ----- rtl/tge_checker.sv -----
module tge_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [tge_pkg::POS_W-1:0]  out_cell_x,
  input logic [tge_pkg::POS_W-1:0]  out_cell_y,
  input logic [1:0]                 out_north_action,
  input logic [tge_pkg::ID_W-1:0]   out_north_id,
  input logic [1:0]                 out_west_action,
  input logic [tge_pkg::ID_W-1:0]   out_west_id,
  input logic [1:0]                 out_east_action,
  input logic [tge_pkg::ID_W-1:0]   out_east_id,
  input logic [1:0]                 out_south_action,
  input logic [tge_pkg::ID_W-1:0]   out_south_id,
  input logic                       out_last_cell
);
  import tge_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_x) && $stable(out_cell_y)
      && $stable(out_north_id) && $stable(out_south_id) && $stable(out_last_cell))
    else $error("result changed while stalled");

  // an edge with no action carries id zero
  a_none_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_north_action != ACT_NONE || out_north_id == '0)
      && (out_west_action != ACT_NONE || out_west_id == '0)
      && (out_east_action != ACT_NONE || out_east_id == '0)
      && (out_south_action != ACT_NONE || out_south_id == '0))
    else $error("id set on absent edge");

  // no edge on the top or left border
  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_y != '0 || out_north_action == ACT_NONE)
      && (out_cell_x != '0 || out_west_action == ACT_NONE))
    else $error("edge reported on grid border");

  // the last cell is never in the first row or column
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_cell |-> out_cell_x != '0 && out_cell_y != '0)
    else $error("last cell at impossible position");

endmodule

bind tile_grid_edge_extractor tge_checker u_tge_checker (.*);
